// ----- src/rrc_pkg.sv -----
// rrc_pkg: types and codes shared by the reconnect retry controller
// request and response payload structs, operation codes, link states, csr indexes
// no dependencies
package rrc_pkg;

   localparam int TIME_W  = 48;
   localparam int COUNT_W = 8;
   localparam int CSR_W   = 32;

   typedef enum logic [2:0] {
      OP_CONNECTED     = 3'd0,
      OP_DROPPED       = 3'd1,
      OP_RECONNECTED   = 3'd2,
      OP_TICK          = 3'd3,
      OP_ATTEMPT_START = 3'd4,
      OP_ATTEMPT_FAIL  = 3'd5,
      OP_CANCEL        = 3'd6,
      OP_MANUAL_RETRY  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      LINK_IDLE        = 3'd0,
      LINK_CONNECTED   = 3'd1,
      LINK_WAITING     = 3'd2,
      LINK_RETRYING    = 3'd3,
      LINK_RECONNECTED = 3'd4,
      LINK_GAVE_UP     = 3'd5,
      LINK_CANCELLED   = 3'd6
   } link_type;

   typedef enum logic [6:0] {
      MODE_IDLE        = 7'b0000001,
      MODE_CONNECTED   = 7'b0000010,
      MODE_WAITING     = 7'b0000100,
      MODE_RETRYING    = 7'b0001000,
      MODE_RECONNECTED = 7'b0010000,
      MODE_GAVE_UP     = 7'b0100000,
      MODE_CANCELLED   = 7'b1000000
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MAX_ATTEMPTS   = 2'd0,
      CSR_RESUME_WINDOW  = 2'd1,
      CSR_RETRY_INTERVAL = 2'd2
   } csr_index_type;

   localparam logic [COUNT_W-1:0] MAX_ATTEMPTS_RESET   = 8'd5;
   localparam logic [CSR_W-1:0]   RESUME_WINDOW_RESET  = 32'd60000;
   localparam logic [CSR_W-1:0]   RETRY_INTERVAL_RESET = 32'd2000;
   localparam logic [COUNT_W-1:0] COUNT_MAX            = '1;
   localparam logic [TIME_W-1:0]  TIME_MAX             = '1;

   typedef struct packed {
      logic [2:0]        operation;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]         link_state;
      logic [COUNT_W-1:0] attempt_count;
      logic               attempt_due;
   } rsp_type;

endpackage

// ----- src/reconnect_retry_controller.sv -----
// reconnect_retry_controller: top level of the link reconnect controller
// holds the request register, the event logic, link state and the response register
// depends on rrc_pkg
//
// Each request is one link event with a millisecond timestamp and gives exactly one
// response with the link state and attempt count after the event, plus an attempt-due
// flag for ticks. A request can be accepted every cycle while responses are taken; its
// response passes through the request register, then one pass of event logic into the
// response register, and is held until taken. While a response waits, one more request
// can sit in the request register before the input stalls. The next request already
// sees the state left by the previous one. The csr port sets the attempt limit, resume
// window and retry interval; write it only while idle.
module reconnect_retry_controller
   import rrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   logic               req_valid_ff;
   req_type            req_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [COUNT_W-1:0] max_attempts_ff;
   logic [CSR_W-1:0]   resume_window_ff;
   logic [CSR_W-1:0]   retry_interval_ff;

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] attempts_ff, attempts_in;
   logic [TIME_W-1:0]  drop_time_ff, drop_time_in;
   logic [TIME_W-1:0]  next_time_ff, next_time_in;

   logic               advance;
   logic [TIME_W-1:0]  now;
   logic [TIME_W-1:0]  elapsed;
   logic               limit_reached;
   logic [TIME_W:0]    next_sum;
   logic               due;
   link_type           link_code;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign now       = req_ff.now_ms;

   // expiry test: attempt limit or resume window passed since drop
   assign elapsed       = now - drop_time_ff;
   assign limit_reached = (attempts_ff >= max_attempts_ff) ||
                          ((now >= drop_time_ff) &&
                           (elapsed > {{(TIME_W-CSR_W){1'b0}}, resume_window_ff}));
   assign next_sum      = {1'b0, now} + {{(TIME_W+1-CSR_W){1'b0}}, retry_interval_ff};

   always_comb begin
      mode_in      = mode_ff;
      attempts_in  = attempts_ff;
      drop_time_in = drop_time_ff;
      next_time_in = next_time_ff;
      due          = 1'b0;
      case (req_ff.operation)
         OP_CONNECTED: begin
            mode_in     = MODE_CONNECTED;
            attempts_in = '0;
         end
         OP_DROPPED: begin
            if (!(mode_ff inside {MODE_WAITING, MODE_RETRYING, MODE_GAVE_UP,
                                  MODE_CANCELLED})) begin
               mode_in      = MODE_WAITING;
               drop_time_in = now;
               next_time_in = now;
               attempts_in  = '0;
            end
         end
         OP_RECONNECTED: begin
            mode_in = MODE_RECONNECTED;
         end
         OP_TICK: begin
            if (mode_ff == MODE_WAITING) begin
               if (limit_reached) begin
                  mode_in = MODE_GAVE_UP;
               end else begin
                  due = (now >= next_time_ff);
               end
            end
         end
         OP_ATTEMPT_START: begin
            mode_in = MODE_RETRYING;
            if (attempts_ff != COUNT_MAX) begin
               attempts_in = attempts_ff + COUNT_W'(1);
            end
            next_time_in = next_sum[TIME_W] ? TIME_MAX : next_sum[TIME_W-1:0];
         end
         OP_ATTEMPT_FAIL: begin
            if (mode_ff == MODE_RETRYING) begin
               mode_in = limit_reached ? MODE_GAVE_UP : MODE_WAITING;
            end
         end
         OP_CANCEL: begin
            if (mode_ff inside {MODE_WAITING, MODE_RETRYING}) begin
               mode_in = MODE_CANCELLED;
            end
         end
         OP_MANUAL_RETRY: begin
            if (mode_ff inside {MODE_GAVE_UP, MODE_CANCELLED}) begin
               mode_in      = MODE_WAITING;
               drop_time_in = now;
               next_time_in = now;
               attempts_in  = '0;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_comb begin
      case (mode_in)
         MODE_IDLE:        link_code = LINK_IDLE;
         MODE_CONNECTED:   link_code = LINK_CONNECTED;
         MODE_WAITING:     link_code = LINK_WAITING;
         MODE_RETRYING:    link_code = LINK_RETRYING;
         MODE_RECONNECTED: link_code = LINK_RECONNECTED;
         MODE_GAVE_UP:     link_code = LINK_GAVE_UP;
         MODE_CANCELLED:   link_code = LINK_CANCELLED;
         default:          link_code = LINK_IDLE;
      endcase
      rsp_in.link_state    = link_code;
      rsp_in.attempt_count = attempts_in;
      rsp_in.attempt_due   = due;
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         attempts_ff  <= '0;
         drop_time_ff <= '0;
         next_time_ff <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         attempts_ff  <= attempts_in;
         drop_time_ff <= drop_time_in;
         next_time_ff <= next_time_in;
      end
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff   <= MAX_ATTEMPTS_RESET;
         resume_window_ff  <= RESUME_WINDOW_RESET;
         retry_interval_ff <= RETRY_INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_ATTEMPTS:   max_attempts_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_RESUME_WINDOW:  resume_window_ff  <= csr_wdata;
            CSR_RETRY_INTERVAL: retry_interval_ff <= csr_wdata;
            default: begin
               max_attempts_ff <= max_attempts_ff;
            end
         endcase
      end
   end

endmodule
